>>> rtl/urrb_pkg.sv
`default_nettype none

package urrb_pkg;

  localparam int unsigned RING_DEPTH_DEF = 64;

  localparam logic CMD_RECEIVE = 1'b0;
  localparam logic CMD_READ    = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic       rx_ready;
    logic [3:0] line_errors;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic        got_byte;
    logic [7:0]  out_byte;
    logic [31:0] bytes_received;
    logic [31:0] line_error_total;
    logic [31:0] dropped_total;
  } out_t;

endpackage

`default_nettype wire

>>> rtl/urrb_mem.sv
`default_nettype none

module urrb_mem #(
  parameter int unsigned RING_DEPTH = urrb_pkg::RING_DEPTH_DEF,
  localparam int unsigned PW = $clog2(RING_DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [PW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic [PW-1:0] rd_addr,
  output logic [7:0]         rd_data
);

  logic [7:0] mem [RING_DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // pass write data through on a same-address read
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data_r <= wr_data;
    end else begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> rtl/urrb_core.sv
`default_nettype none

module urrb_core #(
  parameter int unsigned RING_DEPTH = urrb_pkg::RING_DEPTH_DEF,
  localparam int unsigned PW = $clog2(RING_DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          req_vld,
  input  wire urrb_pkg::in_t req,
  input  wire logic [7:0]    rd_data,
  output logic               wr_en,
  output logic [PW-1:0]      wr_addr,
  output logic [7:0]         wr_data,
  output logic [PW-1:0]      rd_addr,
  output logic               res_vld,
  output urrb_pkg::out_t     res
);

  localparam logic [PW-1:0] LAST = PW'(RING_DEPTH - 1);

  logic [PW-1:0]  write_pos_r, write_pos_nxt;
  logic [PW-1:0]  read_pos_r, read_pos_nxt;
  logic [31:0]    stored_count_r, stored_count_nxt;
  logic [31:0]    error_count_r, error_count_nxt;
  logic [31:0]    drop_count_r, drop_count_nxt;
  logic           res_vld_r;
  urrb_pkg::out_t res_r, res_nxt;

  logic          is_rx, is_rd, rd_hit, full, drop, err;
  logic [PW-1:0] w_adv, r_adv;

  always_comb begin
    is_rx  = req_vld && (req.cmd == urrb_pkg::CMD_RECEIVE);
    is_rd  = req_vld && (req.cmd == urrb_pkg::CMD_READ);
    w_adv  = (write_pos_r == LAST) ? '0 : write_pos_r + PW'(1);
    r_adv  = (read_pos_r == LAST) ? '0 : read_pos_r + PW'(1);
    full   = (w_adv == read_pos_r);
    rd_hit = is_rd && (read_pos_r != write_pos_r);
    wr_en  = is_rx && req.rx_ready && !full;
    drop   = is_rx && req.rx_ready && full;
    err    = is_rx && (req.line_errors != 4'd0);

    write_pos_nxt    = wr_en ? w_adv : write_pos_r;
    read_pos_nxt     = rd_hit ? r_adv : read_pos_r;
    stored_count_nxt = stored_count_r + {31'd0, wr_en};
    error_count_nxt  = error_count_r + {31'd0, err};
    drop_count_nxt   = drop_count_r + {31'd0, drop};

    res_nxt.got_byte         = rd_hit;
    res_nxt.out_byte         = rd_hit ? rd_data : 8'd0;
    res_nxt.bytes_received   = stored_count_nxt;
    res_nxt.line_error_total = error_count_nxt;
    res_nxt.dropped_total    = drop_count_nxt;
  end

  assign wr_addr = write_pos_r;
  assign wr_data = req.rx_byte;
  assign rd_addr = read_pos_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_pos_r    <= '0;
      read_pos_r     <= '0;
      stored_count_r <= '0;
      error_count_r  <= '0;
      drop_count_r   <= '0;
      res_vld_r      <= 1'b0;
    end else begin
      write_pos_r    <= write_pos_nxt;
      read_pos_r     <= read_pos_nxt;
      stored_count_r <= stored_count_nxt;
      error_count_r  <= error_count_nxt;
      drop_count_r   <= drop_count_nxt;
      res_vld_r      <= req_vld;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res_vld = res_vld_r;
  assign res     = res_r;

endmodule

`default_nettype wire

>>> rtl/uart_rx_ring_buffer_top.sv
`default_nettype none

// Receive byte ring with line diagnostics.
// Input: present a request on in_data with start high; it is taken at any
// edge where busy is low. busy stays low, so one request per cycle is taken.
// A request is either a receive event from the line (stores the byte when
// rx_ready is set, counts line errors, drops the byte when the ring is full)
// or a read that returns the oldest byte, or got_byte low when empty.
// Output: every request yields one result on out_data, flagged by out_strobe
// for a single cycle. Results leave in request order: the request register
// feeds the pointer/counter logic, which loads the result register; that
// register drives out_strobe and out_data. Read data comes from a memory
// with registered read, addressed ahead by the next read pointer, which
// keeps the rate at one request per cycle.
// The ring holds RING_DEPTH-1 bytes. Counters wrap at 32 bits.
// Reset clears pointers, counters and pending strobes; ring contents are kept
// but are never returned before being rewritten. No clearing pass is needed.
// The receiver takes every result as it appears.
module uart_rx_ring_buffer_top #(
  parameter int unsigned RING_DEPTH = urrb_pkg::RING_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire urrb_pkg::in_t in_data,
  output logic               out_strobe,
  output urrb_pkg::out_t     out_data
);

  localparam int unsigned PW = $clog2(RING_DEPTH);

  logic          req_vld_r;
  urrb_pkg::in_t req_r;
  logic          wr_en;
  logic [PW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic [PW-1:0] rd_addr;
  logic [7:0]    rd_data;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
    end else begin
      req_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= in_data;
  end

  urrb_mem #(
    .RING_DEPTH(RING_DEPTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  urrb_core #(
    .RING_DEPTH(RING_DEPTH)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .req_vld (req_vld_r),
    .req     (req_r),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .res_vld (out_strobe),
    .res     (out_data)
  );

endmodule

`default_nettype wire
